// ===== hdl/tal_pkg.sv =====
// Shared types and constants for the temperature alarm logger.
package tal_pkg;

	// Configuration register indexes on the write port
	typedef enum logic [2:0] {
		REG_READ_INTERVAL  = 3'd0,
		REG_STORE_INTERVAL = 3'd1,
		REG_MAJOR_LOW      = 3'd2,
		REG_MINOR_LOW      = 3'd3,
		REG_MINOR_HIGH     = 3'd4,
		REG_MAJOR_HIGH     = 3'd5
	} tal_reg_t;

	// Alarm band codes
	typedef enum logic [2:0] {
		BAND_MAJOR_LOW  = 3'd0,
		BAND_MINOR_LOW  = 3'd1,
		BAND_NORMAL     = 3'd2,
		BAND_MINOR_HIGH = 3'd3,
		BAND_MAJOR_HIGH = 3'd4
	} tal_band_t;

	// Reset values of the configuration registers
	localparam logic [31:0] READ_INTERVAL_RST  = 32'd5000;
	localparam logic [31:0] STORE_INTERVAL_RST = 32'd900000;
	localparam logic [7:0]  MAJOR_LOW_RST      = 8'd60;
	localparam logic [7:0]  MINOR_LOW_RST      = 8'd70;
	localparam logic [7:0]  MINOR_HIGH_RST     = 8'd80;
	localparam logic [7:0]  MAJOR_HIGH_RST     = 8'd90;

	// Stream widths
	localparam int IN_TDATA_W  = 88;
	localparam int OUT_TDATA_W = 72;

	// Fahrenheit conversion: F = trunc((9*c + 1600) / 50)
	localparam logic signed [14:0] F_OFFSET = 15'sd1600;
	// floor(x * 5243 / 2^18) == floor(x / 50) for x up to 10807
	localparam logic [12:0] RECIP_50 = 13'd5243;
	localparam int RECIP_SHIFT = 18;

	// Depth of the queue between front and back
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);

	typedef struct packed {
		logic [31:0] read_int;
		logic [31:0] store_int;
		logic [7:0]  major_low;
		logic [7:0]  minor_low;
		logic [7:0]  minor_high;
		logic [7:0]  major_high;
	} tal_cfg_t;

	// One classified poll, handed from front to back
	typedef struct packed {
		logic               read_taken;
		logic signed [10:0] samp_temp;
		logic               store_done;
		logic [5:0]         store_slot;
		logic signed [10:0] rec_temp;
		logic [9:0]         rec_humid;
		logic [31:0]        rec_stamp;
		logic [6:0]         record_count;
		logic               ring_wrapped;
	} tal_entry_t;

endpackage

// ===== hdl/tal_front.sv =====
// Front end: accepts polls, tracks read and store timing and the ring state.
module tal_front import tal_pkg::*; #(
	parameter int LOG_DEPTH = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  tal_cfg_t              cfg,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_TDATA_W-1:0] s_tdata,
	input  logic                  q_full,
	output logic                  push,
	output tal_entry_t            entry
);

	localparam int CNT_W = $clog2(LOG_DEPTH + 1);

	logic [31:0]        last_read_q, last_store_q;
	logic signed [10:0] held_temp_q;
	logic [9:0]         held_humid_q;
	logic [31:0]        held_stamp_q;
	logic [CNT_W-1:0]   next_slot_q, valid_count_q;
	logic               wrap_q;

	logic [31:0]        now_ms, stamp;
	logic               sensor_ok;
	logic signed [10:0] temp_tenths_c;
	logic [9:0]         humid_tenths;

	logic               accept, read_fire, store_fire, ring_full, wrap_d;
	logic [31:0]        since_read, since_store;
	logic signed [10:0] temp_d;
	logic [9:0]         humid_d;
	logic [31:0]        stamp_d;
	logic [CNT_W-1:0]   slot_use, count_d;
	logic [CNT_W+6:0]   slot_ext, count_ext;

	// unpack the input transfer
	assign now_ms        = s_tdata[31:0];
	assign sensor_ok     = s_tdata[32];
	assign temp_tenths_c = s_tdata[43:33];
	assign humid_tenths  = s_tdata[53:44];
	assign stamp         = s_tdata[85:54];

	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;
	assign push     = accept;

	// due checks with wrapping time differences
	assign since_read  = now_ms - last_read_q;
	assign since_store = now_ms - last_store_q;
	assign read_fire   = accept && sensor_ok && (since_read >= cfg.read_int);
	assign store_fire  = accept && (since_store >= cfg.store_int);

	// sample seen by a store in the same poll
	assign temp_d  = read_fire ? temp_tenths_c : held_temp_q;
	assign humid_d = read_fire ? humid_tenths : held_humid_q;
	assign stamp_d = read_fire ? stamp : held_stamp_q;

	// ring slot and wrap handling
	assign ring_full = (next_slot_q >= CNT_W'(LOG_DEPTH));
	assign slot_use  = ring_full ? '0 : next_slot_q;
	assign wrap_d    = wrap_q || (store_fire && ring_full);
	assign count_d   = (store_fire && !wrap_d) ? valid_count_q + 1'b1 : valid_count_q;
	assign slot_ext  = {7'd0, slot_use};
	assign count_ext = {7'd0, count_d};

	always_comb begin
		entry              = '0;
		entry.read_taken   = read_fire;
		entry.samp_temp    = temp_tenths_c;
		entry.store_done   = store_fire;
		entry.record_count = count_ext[6:0];
		entry.ring_wrapped = wrap_d;
		if (store_fire) begin
			entry.store_slot = slot_ext[5:0];
			entry.rec_temp   = temp_d;
			entry.rec_humid  = humid_d;
			entry.rec_stamp  = stamp_d;
		end
	end

	// state update on each accepted poll
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_read_q   <= '0;
			last_store_q  <= '0;
			held_temp_q   <= '0;
			held_humid_q  <= '0;
			held_stamp_q  <= '0;
			next_slot_q   <= '0;
			valid_count_q <= '0;
			wrap_q        <= 1'b0;
		end else begin
			if (read_fire) begin
				last_read_q  <= now_ms;
				held_temp_q  <= temp_tenths_c;
				held_humid_q <= humid_tenths;
				held_stamp_q <= stamp;
			end
			if (store_fire) begin
				last_store_q  <= now_ms;
				next_slot_q   <= slot_use + 1'b1;
				valid_count_q <= count_d;
				wrap_q        <= wrap_d;
			end
		end
	end

endmodule

// ===== hdl/tal_queue.sv =====
// Short queue of classified polls between front and back.
module tal_queue import tal_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  tal_entry_t push_data,
	output logic       full,
	input  logic       pop,
	output logic       avail,
	output tal_entry_t pop_data
);

	tal_entry_t        mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QPTR_W:0]   count_q;
	logic              do_push, do_pop;

	assign full     = (count_q == (QPTR_W+1)'(QDEPTH));
	assign avail    = (count_q != '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && avail;
	assign pop_data = mem_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== hdl/tal_back.sv =====
// Back end: Fahrenheit conversion, alarm banding and the output register.
module tal_back import tal_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  tal_cfg_t               cfg,
	input  logic                   q_avail,
	input  tal_entry_t             q_data,
	output logic                   pop,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata
);

	tal_entry_t         ent_s1;
	logic               valid_s1, neg_s1;
	logic [25:0]        prod_s1;
	logic               adv_out, adv_s1;

	logic signed [14:0] t_ext, num;
	logic               neg;
	logic [13:0]        mag;
	logic [7:0]         quo;
	logic signed [9:0]  fahr;
	tal_band_t          band;
	logic [2:0]         level;

	assign adv_out = !m_tvalid || m_tready;
	assign adv_s1  = !valid_s1 || adv_out;
	assign pop     = q_avail && adv_s1;

	// 9*c + 1600, then magnitude for the reciprocal multiply
	assign t_ext = {{4{q_data.samp_temp[10]}}, q_data.samp_temp};
	assign num   = (t_ext <<< 3) + t_ext + F_OFFSET;
	assign neg   = num[14];
	assign mag   = neg ? 14'(-num) : num[13:0];

	// stage 1: divide by 50 through a reciprocal product
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= q_avail;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			ent_s1  <= q_data;
			neg_s1  <= neg;
			prod_s1 <= {12'd0, mag} * {13'd0, RECIP_50};
		end
	end

	// truncate toward zero and walk the band chain in order
	assign quo  = prod_s1[RECIP_SHIFT+7:RECIP_SHIFT];
	assign fahr = neg_s1 ? -$signed({2'b00, quo}) : $signed({2'b00, quo});

	always_comb begin
		priority if (fahr <= $signed({2'b00, cfg.major_low})) begin
			band = BAND_MAJOR_LOW;
		end else if (fahr <= $signed({2'b00, cfg.minor_low})) begin
			band = BAND_MINOR_LOW;
		end else if (fahr <= $signed({2'b00, cfg.minor_high})) begin
			band = BAND_NORMAL;
		end else if (fahr <= $signed({2'b00, cfg.major_high})) begin
			band = BAND_MINOR_HIGH;
		end else begin
			band = BAND_MAJOR_HIGH;
		end
	end

	assign level = ent_s1.read_taken ? band : BAND_MAJOR_LOW;

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (adv_out) begin
			m_tvalid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_out && valid_s1) begin
			m_tdata <= {ent_s1.ring_wrapped, ent_s1.record_count, ent_s1.rec_stamp,
			            ent_s1.rec_humid, ent_s1.rec_temp, ent_s1.store_slot,
			            ent_s1.store_done, level, ent_s1.read_taken};
		end
	end

endmodule

// ===== hdl/temperature_alarm_logger.sv =====
// Top level of the temperature alarm logger: configuration registers and the pipeline.
// Throughput: one poll per clock; s_tready drops only while the four-entry queue is full.
// Path: a poll accepted on s_tdata is written into the queue, then passes the
// reciprocal multiply stage and the output register before it shows on m_tdata.
// Reset: arst_n clears timing, held sample, ring state and valid flags at once;
// configuration returns to its default values. No clearing pass.
module temperature_alarm_logger import tal_pkg::*; #(
	parameter int LOG_DEPTH = 64
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [2:0]             cfg_idx,
	input  logic [31:0]            cfg_data,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// now_ms[31:0], sensor_ok[32], temp_tenths_c[43:33], humid_tenths[53:44],
	// stamp[85:54], zero pad[87:86]
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// read_taken[0], alarm_level[3:1], store_done[4], store_slot[10:5],
	// rec_temp[21:11], rec_humid[31:22], rec_stamp[63:32], record_count[70:64],
	// ring_wrapped[71]
	output logic [OUT_TDATA_W-1:0] m_tdata
);

	tal_cfg_t   cfg_q;
	logic       push, q_full, q_avail, pop;
	tal_entry_t push_data, pop_data;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.read_int   <= READ_INTERVAL_RST;
			cfg_q.store_int  <= STORE_INTERVAL_RST;
			cfg_q.major_low  <= MAJOR_LOW_RST;
			cfg_q.minor_low  <= MINOR_LOW_RST;
			cfg_q.minor_high <= MINOR_HIGH_RST;
			cfg_q.major_high <= MAJOR_HIGH_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_READ_INTERVAL:  cfg_q.read_int   <= cfg_data;
				REG_STORE_INTERVAL: cfg_q.store_int  <= cfg_data;
				REG_MAJOR_LOW:      cfg_q.major_low  <= cfg_data[7:0];
				REG_MINOR_LOW:      cfg_q.minor_low  <= cfg_data[7:0];
				REG_MINOR_HIGH:     cfg_q.minor_high <= cfg_data[7:0];
				REG_MAJOR_HIGH:     cfg_q.major_high <= cfg_data[7:0];
				default:            cfg_q            <= cfg_q;
			endcase
		end
	end

	tal_front #(
		.LOG_DEPTH(LOG_DEPTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.q_full   (q_full),
		.push     (push),
		.entry    (push_data)
	);

	tal_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (pop),
		.avail     (q_avail),
		.pop_data  (pop_data)
	);

	tal_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.q_avail  (q_avail),
		.q_data   (pop_data),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule
